@@ design/sstt_pkg.sv @@
// Shared types and constants for the session state handshake tracker.
package sstt_pkg;

    localparam int unsigned SeqW   = 64;
    localparam int unsigned GenW   = 64;
    localparam int unsigned TicksW = 32;
    localparam int unsigned AddrW  = 3;
    localparam int unsigned DataW  = 32;

    localparam logic [TicksW-1:0] TimeoutReset = TicksW'(1000);
    localparam logic [GenW-1:0]   GenMax       = '1;

    typedef enum logic [2:0] {
        CMD_CONFIGURE   = 3'd0,
        CMD_REQ_INACT   = 3'd1,
        CMD_REQ_ACT     = 3'd2,
        CMD_ACK         = 3'd3,
        CMD_TICK        = 3'd4,
        CMD_DISCONNECT  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_DISABLED   = 3'd0,
        MODE_ACTIVE     = 3'd1,
        MODE_INACTIVE   = 3'd2,
        MODE_AWAIT_INACT = 3'd3,
        MODE_AWAIT_ACT  = 3'd4,
        MODE_FAILED     = 3'd5
    } t_mode;

    typedef enum logic [3:0] {
        ERR_NONE        = 4'd0,
        ERR_BAD_INACT   = 4'd1,
        ERR_BAD_ACT     = 4'd2,
        ERR_EXHAUSTED   = 4'd3,
        ERR_ENQUEUE     = 4'd4,
        ERR_MISMATCH    = 4'd5,
        ERR_UNAVAILABLE = 4'd6,
        ERR_REJECTED    = 4'd7,
        ERR_TIMEOUT     = 4'd8
    } t_err;

    typedef enum logic [1:0] {
        ACK_ACCEPTED    = 2'd0,
        ACK_APPLIED     = 2'd1,
        ACK_UNAVAILABLE = 2'd2,
        ACK_REJECTED    = 2'd3
    } t_ack;

    localparam logic TargetActive   = 1'b0;
    localparam logic TargetInactive = 1'b1;

    localparam logic [AddrW-1:0] AddrTimeout = AddrW'(0);

    typedef struct packed {
        logic [2:0]      cmd;
        logic            negotiated;
        logic            enqueue_ok;
        logic [SeqW-1:0] seq_number;
        logic [GenW-1:0] ack_generation;
        logic            ack_state;
        logic [1:0]      ack_result;
    } t_in_item;

    typedef struct packed {
        logic              ok;
        logic [3:0]        error_code;
        logic [2:0]        coord_state;
        logic              send_request;
        logic [GenW-1:0]   req_generation;
        logic              req_state;
        logic              is_waiting;
        logic [TicksW-1:0] remaining_ticks;
    } t_out_item;

    typedef struct packed {
        t_mode             mode;
        logic [GenW-1:0]   generation;
        logic [SeqW-1:0]   pending_seq;
        logic              pending_target;
        logic [TicksW-1:0] countdown;
    } t_state;

    function automatic logic mode_awaiting(input t_mode m);
        return (m == MODE_AWAIT_INACT) || (m == MODE_AWAIT_ACT);
    endfunction

endpackage

@@ design/sstt_core.sv @@
// Next-state and result logic for one command of the handshake tracker.
module sstt_core
    import sstt_pkg::*;
(
    input  sstt_pkg::t_state        i_state,
    input  sstt_pkg::t_in_item      i_item,
    input  logic [sstt_pkg::TicksW-1:0] i_timeout,
    output sstt_pkg::t_state        o_state,
    output sstt_pkg::t_out_item     o_result
);

    t_state            n_st;
    logic              ok;
    t_err              err;
    logic              sent;
    logic              target;
    logic              waiting;
    logic              ack_match;
    logic [TicksW-1:0] cd_dec;

    always_comb begin
        n_st      = i_state;
        ok        = 1'b0;
        err       = ERR_NONE;
        sent      = 1'b0;
        target    = (i_item.cmd == CMD_REQ_INACT) ? TargetInactive : TargetActive;
        waiting   = mode_awaiting(i_state.mode);
        ack_match = waiting && (i_item.seq_number == i_state.pending_seq)
                    && (i_item.ack_generation == i_state.generation)
                    && (i_item.ack_state == i_state.pending_target);
        cd_dec    = (i_state.countdown == '0) ? '0 : i_state.countdown - TicksW'(1);

        unique case (i_item.cmd)
            CMD_CONFIGURE: begin
                n_st.mode           = i_item.negotiated ? MODE_ACTIVE : MODE_DISABLED;
                n_st.generation     = '0;
                n_st.pending_seq    = '0;
                n_st.pending_target = TargetActive;
                n_st.countdown      = '0;
                ok                  = 1'b1;
            end
            CMD_REQ_INACT, CMD_REQ_ACT: begin
                priority if (i_item.cmd == CMD_REQ_INACT && i_state.mode != MODE_ACTIVE) begin
                    err = ERR_BAD_INACT;
                end else if (i_item.cmd == CMD_REQ_ACT && i_state.mode != MODE_INACTIVE) begin
                    err = ERR_BAD_ACT;
                end else if (i_state.generation == GenMax) begin
                    err       = ERR_EXHAUSTED;
                    n_st.mode = MODE_FAILED;
                end else if (!i_item.enqueue_ok || i_item.seq_number == '0) begin
                    err       = ERR_ENQUEUE;
                    n_st.mode = MODE_FAILED;
                end else begin
                    n_st.generation     = i_state.generation + GenW'(1);
                    n_st.pending_seq    = i_item.seq_number;
                    n_st.pending_target = target;
                    n_st.countdown      = i_timeout;
                    n_st.mode = (target == TargetInactive) ? MODE_AWAIT_INACT
                                                           : MODE_AWAIT_ACT;
                    ok   = 1'b1;
                    sent = 1'b1;
                end
            end
            CMD_ACK: begin
                priority if (!ack_match) begin
                    err       = ERR_MISMATCH;
                    n_st.mode = MODE_FAILED;
                end else if (i_item.ack_result == ACK_UNAVAILABLE) begin
                    err       = ERR_UNAVAILABLE;
                    n_st.mode = MODE_FAILED;
                end else if (i_item.ack_result == ACK_REJECTED) begin
                    err       = ERR_REJECTED;
                    n_st.mode = MODE_FAILED;
                end else begin
                    n_st.mode = (i_state.pending_target == TargetInactive) ? MODE_INACTIVE
                                                                           : MODE_ACTIVE;
                    n_st.pending_seq = '0;
                    ok               = 1'b1;
                end
            end
            CMD_TICK: begin
                if (waiting) begin
                    n_st.countdown = cd_dec;
                    if (cd_dec == '0) begin
                        err       = ERR_TIMEOUT;
                        n_st.mode = MODE_FAILED;
                    end else begin
                        ok = 1'b1;
                    end
                end else begin
                    ok = 1'b1;
                end
            end
            CMD_DISCONNECT: begin
                n_st.mode        = waiting ? MODE_FAILED : MODE_DISABLED;
                n_st.pending_seq = '0;
                ok               = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_state = n_st;

    always_comb begin
        o_result.ok              = ok;
        o_result.error_code      = err;
        o_result.coord_state     = n_st.mode;
        o_result.send_request    = sent;
        o_result.req_generation  = sent ? n_st.generation : '0;
        o_result.req_state       = sent ? target : 1'b0;
        o_result.is_waiting      = mode_awaiting(n_st.mode);
        o_result.remaining_ticks = mode_awaiting(n_st.mode) ? n_st.countdown : '0;
    end

endmodule

@@ design/session_state_handshake_tracker.sv @@
// Top level of the session state handshake tracker: state, result register, APB register.
// A result is registered and is valid in the cycle after its command is accepted.
// Throughput: one command per cycle; the single result register holds one transfer and
// is refilled in the cycle it is taken, so the input stalls only while a result waits.
// Reset (synchronous, active low): mode disabled, generation, pending sequence and
// countdown zero, target active, timeout_ticks 1000, no result pending.
module session_state_handshake_tracker
    import sstt_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  sstt_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output sstt_pkg::t_out_item           o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sstt_pkg::AddrW-1:0]    paddr,
    input  logic [sstt_pkg::DataW-1:0]    pwdata,
    output logic [sstt_pkg::DataW-1:0]    prdata,
    output logic                          pready
);

    t_state            r_state;
    t_state            n_state;
    t_out_item         r_out;
    t_out_item         n_out;
    logic              r_out_valid;
    logic [TicksW-1:0] r_timeout;
    logic              in_fire;
    logic              cfg_sel;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;
    assign cfg_sel     = (paddr[AddrW-1] == AddrTimeout[AddrW-1]);
    assign prdata      = cfg_sel ? DataW'(r_timeout) : '0;

    sstt_core u_core (
        .i_state   (r_state),
        .i_item    (i_in_item),
        .i_timeout (r_timeout),
        .o_state   (n_state),
        .o_result  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode           <= MODE_DISABLED;
            r_state.generation     <= '0;
            r_state.pending_seq    <= '0;
            r_state.pending_target <= TargetActive;
            r_state.countdown      <= '0;
            r_out_valid            <= 1'b0;
            r_timeout              <= TimeoutReset;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (psel && penable && pwrite && cfg_sel) begin
                r_timeout <= pwdata[TicksW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    a_wait_has_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mode_awaiting(r_state.mode) |-> (r_state.generation != '0))
        else $error("awaiting with zero generation");

    a_wait_has_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mode_awaiting(r_state.mode) |-> (r_state.pending_seq != '0))
        else $error("awaiting with zero pending sequence");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_out_valid)
        else $error("accepted command left no result");

    a_sent_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.send_request) |->
            (o_out_item.is_waiting && o_out_item.ok && o_out_item.req_generation != '0))
        else $error("issued request without awaiting state");

    a_wait_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.is_waiting) |->
            (o_out_item.coord_state == MODE_AWAIT_INACT
             || o_out_item.coord_state == MODE_AWAIT_ACT))
        else $error("waiting flag disagrees with state");

endmodule

@@ dv/sstt_tb_pkg.sv @@
// Scoreboard class: predicts each tracker result and checks the block's results against it.
`timescale 1ns / 100ps

package sstt_tb_pkg;

    import sstt_pkg::*;

    class session_tracker_scoreboard;

        t_mode             mode;
        logic [GenW-1:0]   generation;
        logic [SeqW-1:0]   pending_seq;
        logic              pending_target;
        logic [TicksW-1:0] countdown;
        logic [TicksW-1:0] timeout_ticks;
        t_out_item         awaited_results[$];
        int unsigned       errors;

        function new();
            timeout_ticks = TimeoutReset;
            mode = MODE_DISABLED;
            generation = '0;
            pending_seq = '0;
            pending_target = TargetActive;
            countdown = '0;
            errors = 0;
        endfunction

        function logic waiting();
            return (mode == MODE_AWAIT_INACT) || (mode == MODE_AWAIT_ACT);
        endfunction

        function void note_command(input t_in_item it);
            t_out_item r;
            r = '0;
            case (it.cmd)
                CMD_CONFIGURE: begin
                    mode = it.negotiated ? MODE_ACTIVE : MODE_DISABLED;
                    generation = '0;
                    pending_seq = '0;
                    pending_target = TargetActive;
                    countdown = '0;
                    r.ok = 1'b1;
                end
                CMD_REQ_INACT, CMD_REQ_ACT: begin
                    if (it.cmd == CMD_REQ_INACT && mode != MODE_ACTIVE) begin
                        r.error_code = ERR_BAD_INACT;
                    end else if (it.cmd == CMD_REQ_ACT && mode != MODE_INACTIVE) begin
                        r.error_code = ERR_BAD_ACT;
                    end else if (generation == GenMax) begin
                        mode = MODE_FAILED;
                        r.error_code = ERR_EXHAUSTED;
                    end else if (!it.enqueue_ok || it.seq_number == '0) begin
                        mode = MODE_FAILED;
                        r.error_code = ERR_ENQUEUE;
                    end else begin
                        generation = generation + 1'b1;
                        pending_seq = it.seq_number;
                        pending_target = (it.cmd == CMD_REQ_INACT) ? TargetInactive
                                                                   : TargetActive;
                        countdown = timeout_ticks;
                        mode = (pending_target == TargetInactive) ? MODE_AWAIT_INACT
                                                                  : MODE_AWAIT_ACT;
                        r.ok = 1'b1;
                        r.send_request = 1'b1;
                        r.req_generation = generation;
                        r.req_state = pending_target;
                    end
                end
                CMD_ACK: begin
                    if (!waiting() || it.seq_number != pending_seq ||
                        it.ack_generation != generation || it.ack_state != pending_target) begin
                        r.error_code = ERR_MISMATCH;
                        mode = MODE_FAILED;
                    end else if (it.ack_result == ACK_UNAVAILABLE) begin
                        r.error_code = ERR_UNAVAILABLE;
                        mode = MODE_FAILED;
                    end else if (it.ack_result == ACK_REJECTED) begin
                        r.error_code = ERR_REJECTED;
                        mode = MODE_FAILED;
                    end else begin
                        mode = (pending_target == TargetInactive) ? MODE_INACTIVE : MODE_ACTIVE;
                        pending_seq = '0;
                        r.ok = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (waiting()) begin
                        if (countdown != '0) countdown = countdown - 1'b1;
                        if (countdown == '0) begin
                            r.error_code = ERR_TIMEOUT;
                            mode = MODE_FAILED;
                        end else begin
                            r.ok = 1'b1;
                        end
                    end else begin
                        r.ok = 1'b1;
                    end
                end
                CMD_DISCONNECT: begin
                    mode = waiting() ? MODE_FAILED : MODE_DISABLED;
                    pending_seq = '0;
                    r.ok = 1'b1;
                end
                default: begin
                end
            endcase
            r.coord_state = mode;
            r.is_waiting = waiting();
            r.remaining_ticks = waiting() ? countdown : '0;
            awaited_results.push_back(r);
        endfunction

        task report(input string what, input logic [63:0] got, input logic [63:0] want);
            $display("%0t: result mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
            errors++;
        endtask

        task check_result(input t_out_item got);
            t_out_item want;
            if (awaited_results.size() == 0) begin
                report("unrequested transfer", 64'(got.coord_state), '0);
                return;
            end
            want = awaited_results.pop_front();
            if (got.ok !== want.ok) report("ok", 64'(got.ok), 64'(want.ok));
            if (got.error_code !== want.error_code)
                report("error_code", 64'(got.error_code), 64'(want.error_code));
            if (got.coord_state !== want.coord_state)
                report("coord_state", 64'(got.coord_state), 64'(want.coord_state));
            if (got.send_request !== want.send_request)
                report("send_request", 64'(got.send_request), 64'(want.send_request));
            if (got.req_generation !== want.req_generation)
                report("req_generation", got.req_generation, want.req_generation);
            if (got.req_state !== want.req_state)
                report("req_state", 64'(got.req_state), 64'(want.req_state));
            if (got.is_waiting !== want.is_waiting)
                report("is_waiting", 64'(got.is_waiting), 64'(want.is_waiting));
            if (got.remaining_ticks !== want.remaining_ticks)
                report("remaining_ticks", 64'(got.remaining_ticks),
                       64'(want.remaining_ticks));
        endtask

    endclass

endpackage

@@ dv/tb_top.sv @@
// Top of the handshake tracker testbench: clock, reset, command and result drivers, run control.
`timescale 1ns / 100ps

module tb_top;

    import sstt_pkg::*;
    import sstt_tb_pkg::*;

    localparam logic [2:0] CmdSpareLo = 3'd6;
    localparam logic [2:0] CmdSpareHi = 3'd7;
    localparam int unsigned NumPhases = 7;
    localparam int unsigned PhaseItems = 150;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_item         i_in_item;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_item        o_out_item;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    session_tracker_scoreboard sb;
    logic                      no_idle = 1'b0;
    int unsigned               results_taken = 0;

    session_state_handshake_tracker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_item mk(input logic [2:0] cmd, input logic negotiated,
                                    input logic enq, input logic [SeqW-1:0] seq);
        t_in_item it;
        it = '0;
        it.cmd = cmd;
        it.negotiated = negotiated;
        it.enqueue_ok = enq;
        it.seq_number = seq;
        return it;
    endfunction

    function automatic t_in_item ack_cmd(input t_ack res);
        t_in_item it;
        it = mk(CMD_ACK, 1'b0, 1'b0, sb.pending_seq);
        it.ack_generation = sb.generation;
        it.ack_state = sb.pending_target;
        it.ack_result = res;
        return it;
    endfunction

    function automatic t_in_item noise_cmd();
        t_in_item it;
        it.cmd = 3'($urandom_range(0, 7));
        it.negotiated = 1'($urandom);
        it.enqueue_ok = 1'($urandom);
        it.seq_number = {$urandom, $urandom};
        it.ack_generation = {$urandom, $urandom};
        it.ack_state = 1'($urandom);
        it.ack_result = 2'($urandom);
        return it;
    endfunction

    // Mostly well-formed handshakes with random content; some noise and broken acks.
    function automatic t_in_item shaped_cmd();
        t_in_item    it;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return noise_cmd();
        it = noise_cmd();
        case (sb.mode)
            MODE_ACTIVE, MODE_INACTIVE: begin
                it.cmd = (sb.mode == MODE_ACTIVE) ? CMD_REQ_INACT : CMD_REQ_ACT;
                it.enqueue_ok = ($urandom_range(0, 19) != 0);
                if (roll < 11) it.seq_number = '0;
            end
            MODE_AWAIT_INACT, MODE_AWAIT_ACT: begin
                if (roll < 45) begin
                    it.cmd = CMD_TICK;
                end else if (roll < 50) begin
                    it.cmd = CMD_DISCONNECT;
                end else begin
                    if (roll < 85) it = ack_cmd(ACK_ACCEPTED);
                    else if (roll < 92) it = ack_cmd(ACK_APPLIED);
                    else if (roll < 96) it = ack_cmd(ACK_UNAVAILABLE);
                    else it = ack_cmd(ACK_REJECTED);
                    if ($urandom_range(0, 15) == 0) begin
                        case ($urandom_range(0, 2))
                            0: it.seq_number = it.seq_number ^ (64'd1 << $urandom_range(0, 63));
                            1: it.ack_generation =
                                   it.ack_generation ^ (64'd1 << $urandom_range(0, 63));
                            default: it.ack_state = ~it.ack_state;
                        endcase
                    end
                end
            end
            default: begin
                it.cmd = CMD_CONFIGURE;
                it.negotiated = ($urandom_range(0, 9) != 0);
            end
        endcase
        return it;
    endfunction

    // Call just after a rising edge; returns at the edge where the transfer happens.
    task automatic push_cmd(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_command(it);
    endtask

    task automatic idle_then_push(input t_in_item it);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push_cmd(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [TicksW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AddrTimeout;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.timeout_ticks = value;
    endtask

    task automatic run_directed();
        t_in_item it;
        idle_then_push(mk(CMD_CONFIGURE, 1'b0, 1'b0, '0));
        idle_then_push(mk(CMD_REQ_INACT, 1'b0, 1'b1, 64'd7));
        idle_then_push(mk(CMD_REQ_ACT, 1'b0, 1'b1, 64'd7));
        idle_then_push(mk(CMD_TICK, 1'b0, 1'b0, '0));
        idle_then_push(mk(CmdSpareLo, 1'b1, 1'b1, '1));
        idle_then_push(mk(CmdSpareHi, 1'b1, 1'b1, '1));
        idle_then_push(ack_cmd(ACK_ACCEPTED));
        idle_then_push(mk(CMD_CONFIGURE, 1'b1, 1'b0, '0));
        idle_then_push(mk(CMD_REQ_INACT, 1'b0, 1'b0, 64'd3));
        idle_then_push(mk(CMD_CONFIGURE, 1'b1, 1'b0, '0));
        idle_then_push(mk(CMD_REQ_INACT, 1'b0, 1'b1, '0));
        idle_then_push(mk(CMD_CONFIGURE, 1'b1, 1'b0, '0));
        idle_then_push(mk(CMD_REQ_INACT, 1'b0, 1'b1, '1));
        idle_then_push(mk(CMD_TICK, 1'b0, 1'b0, '0));
        it = ack_cmd(ACK_ACCEPTED);
        it.ack_generation = GenMax;
        idle_then_push(it);
        idle_then_push(mk(CMD_CONFIGURE, 1'b1, 1'b0, '0));
        idle_then_push(mk(CMD_REQ_INACT, 1'b0, 1'b1, 64'd5));
        idle_then_push(ack_cmd(ACK_ACCEPTED));
        idle_then_push(mk(CMD_REQ_ACT, 1'b0, 1'b1, '1));
        idle_then_push(ack_cmd(ACK_APPLIED));
        idle_then_push(mk(CMD_REQ_INACT, 1'b0, 1'b1, 64'd9));
        idle_then_push(ack_cmd(ACK_UNAVAILABLE));
        idle_then_push(mk(CMD_CONFIGURE, 1'b1, 1'b0, '0));
        idle_then_push(mk(CMD_REQ_INACT, 1'b0, 1'b1, 64'd11));
        idle_then_push(ack_cmd(ACK_REJECTED));
        idle_then_push(mk(CMD_CONFIGURE, 1'b1, 1'b0, '0));
        idle_then_push(mk(CMD_REQ_INACT, 1'b0, 1'b1, 64'd13));
        idle_then_push(mk(CMD_DISCONNECT, 1'b0, 1'b0, '0));
        idle_then_push(mk(CMD_DISCONNECT, 1'b0, 1'b0, '0));
    endtask

    function automatic logic [TicksW-1:0] phase_timeout(input int unsigned phase);
        case (phase)
            1: return '0;
            2: return TicksW'(1);
            3: return TicksW'(4);
            4: return '1;
            5: return TicksW'($urandom_range(2, 8));
            6: return TicksW'(2);
            default: return TimeoutReset;
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_item);
            results_taken++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && prdata !== DataW'(sb.timeout_ticks)) begin
            sb.report("timeout_ticks readback", 64'(prdata), 64'(sb.timeout_ticks));
        end
    end

    initial begin : result_side
        int unsigned stall_left;
        logic        held;
        stall_left = 0;
        held = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && results_taken >= 500) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            if (stall_left == 0 && $urandom_range(0, 2) == 0) stall_left = pick_gap();
            if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : command_side
        int unsigned phase;
        int unsigned n;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (phase = 0; phase < NumPhases; phase++) begin
            drain();
            if (phase != 0) write_timeout(phase_timeout(phase));
            no_idle = (phase % 3 == 2);
            for (n = 0; n < PhaseItems; n++) begin
                if (phase == 3 && n == PhaseItems / 2) drain();
                idle_then_push(shaped_cmd());
            end
        end
        drain();
        repeat (5) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("session_state_handshake_tracker regression: pass");
        end else begin
            $display("session_state_handshake_tracker regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #10000000;
        $display("session_state_handshake_tracker regression: fail");
        $finish;
    end

endmodule
